// ===== rtl/fpp_pkg.sv =====
// shared constants and types for the point projection block
package fpp_pkg;
  localparam int WordW     = 32;
  localparam int CfgW      = 64;
  localparam int CfgIdxW   = 3;
  localparam int CenterW   = 12;
  localparam int ScreenW   = 16;
  localparam int ScaleW    = 15;
  localparam int FracShift = 8;
  localparam int DepthMin  = 32'h400;
  localparam int ScaleNum  = 32'h100_0000;
  localparam int DivSteps  = 32;

  localparam logic [CfgIdxW-1:0] RegRow0Lin  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRow0Rest = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRow1Lin  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRow1Rest = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRow2Lin  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRow2Rest = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCenterX  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegCenterY  = 3'd7;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_height;
  } point_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] depth;
    logic               visible;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic        [14:0] sprite_scale;
  } proj_t;
endpackage

// ===== rtl/fpp_if.sv =====
// valid/ready channel carrying one request payload
interface fpp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fpp_divider.sv =====
// pipelined unsigned restoring divider, one quotient bit per stage
module fpp_divider import fpp_pkg::*; #(
  parameter int Steps = DivSteps,
  parameter int TagW  = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [Steps-1:0] dividend,
  input  logic [Steps-1:0] divisor,
  input  logic [TagW-1:0]  in_tag,
  output logic             out_valid,
  output logic [Steps-1:0] quotient,
  output logic [TagW-1:0]  out_tag
);
  logic [Steps-1:0] rem_q [1:Steps];
  logic [Steps-1:0] num_q [1:Steps];
  logic [Steps-1:0] den_q [1:Steps];
  logic [TagW-1:0]  tag_q [1:Steps];
  logic             vld_q [1:Steps];

  // one stage: shift in a numerator bit, try subtract
  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [Steps-1:0] rem_i, num_i, den_i;
    logic [TagW-1:0]  tag_i;
    logic             vld_i;
    logic [Steps:0]   trial;

    // stage inputs: the request itself or the previous stage
    if (s == 0) begin : g_first
      assign rem_i = '0;
      assign num_i = dividend;
      assign den_i = divisor;
      assign tag_i = in_tag;
      assign vld_i = in_valid;
    end else begin : g_next
      assign rem_i = rem_q[s];
      assign num_i = num_q[s];
      assign den_i = den_q[s];
      assign tag_i = tag_q[s];
      assign vld_i = vld_q[s];
    end

    assign trial = {rem_i, num_i[Steps-1]} - {1'b0, den_i};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s+1] <= 1'b0;
      end else if (en) begin
        vld_q[s+1] <= vld_i;
      end
      if (en) begin
        den_q[s+1] <= den_i;
        tag_q[s+1] <= tag_i;
        if (!trial[Steps]) begin
          rem_q[s+1] <= trial[Steps-1:0];
          num_q[s+1] <= {num_i[Steps-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= {rem_i[Steps-2:0], num_i[Steps-1]};
          num_q[s+1] <= {num_i[Steps-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld_q[Steps];
  assign quotient  = num_q[Steps];
  assign out_tag   = tag_q[Steps];
endmodule

// ===== rtl/fixed_point_point_projection.sv =====
// Point projection: 3x4 fixed-point camera transform then perspective divide.
// One point per cycle while the output is not stalled; the stages are an input
// register, products, two adder stages, one pipelined divider stage per quotient
// bit, and an output stage. The whole pipeline advances when the output register
// is empty or being taken, so a stall holds every stage.
module fixed_point_point_projection import fpp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  fpp_if.sink                in_ch,
  fpp_if.source              out_ch
);
  logic [CfgW-1:0]    mat [6];
  logic [CenterW-1:0] cx, cy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) mat[i] <= '0;
      cx <= CenterW'(212);
      cy <= CenterW'(120);
    end else if (cfg_we) begin
      case (cfg_index)
        RegRow0Lin, RegRow0Rest, RegRow1Lin,
        RegRow1Rest, RegRow2Lin, RegRow2Rest: mat[cfg_index] <= cfg_data;
        RegCenterX: cx <= cfg_data[CenterW-1:0];
        RegCenterY: cy <= cfg_data[CenterW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: shifted inputs
  logic        v1;
  logic [31:0] x1, y1, z1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_ch.valid;
    if (en) begin
      x1 <= 32'($signed(in_ch.data.pos_x) >>> FracShift);
      z1 <= 32'($signed(in_ch.data.pos_z) >>> FracShift);
      y1 <= 32'($signed(in_ch.data.pos_height) >>> FracShift);
    end
  end

  // stage 2: wrapped products, shifted
  logic        v2;
  logic [31:0] p2 [3][3];
  logic [31:0] t2 [3];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        logic [31:0] m0, m1, m2;
        m0 = 32'(x1 * mat[2*r][31:0]);
        m1 = 32'(y1 * mat[2*r][63:32]);
        m2 = 32'(z1 * mat[2*r+1][31:0]);
        p2[r][0] <= 32'($signed(m0) >>> FracShift);
        p2[r][1] <= 32'($signed(m1) >>> FracShift);
        p2[r][2] <= 32'($signed(m2) >>> FracShift);
        t2[r] <= mat[2*r+1][63:32];
      end
    end
  end

  // stage 3: partial sums
  logic        v3;
  logic [31:0] a3 [3];
  logic [31:0] b3 [3];
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        a3[r] <= t2[r] + p2[r][0];
        b3[r] <= p2[r][1] + p2[r][2];
      end
    end
  end

  // stage 4: row results
  logic        v4;
  logic [31:0] w4 [3];
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      for (int r = 0; r < 3; r++) w4[r] <= a3[r] + b3[r];
    end
  end

  // divider operands: magnitudes, signs ride in the tag
  logic        vis4;
  logic [31:0] nx4, ny4, dabs4, mx4, my4;
  assign vis4  = $signed(w4[2]) >= $signed(32'(DepthMin));
  assign dabs4 = w4[2];
  assign nx4   = {w4[0][23:0], 8'd0};
  assign ny4   = {w4[1][23:0], 8'd0};
  assign mx4   = nx4[31] ? 32'(-nx4) : nx4;
  assign my4   = ny4[31] ? 32'(-ny4) : ny4;

  localparam int TagW = 3 * 32 + 3;
  logic [TagW-1:0] tag_in, tx, ty, ts;
  logic vx, vy, vs;
  logic [DivSteps-1:0] qx, qy, qs;
  assign tag_in = {w4[0], w4[1], w4[2], vis4, nx4[31], ny4[31]};

  fpp_divider #(.Steps(DivSteps), .TagW(TagW)) u_div_x (
    .clk, .rst, .en, .in_valid(v4), .dividend(DivSteps'(mx4)),
    .divisor(DivSteps'(dabs4)), .in_tag(tag_in), .out_valid(vx),
    .quotient(qx), .out_tag(tx));
  fpp_divider #(.Steps(DivSteps), .TagW(TagW)) u_div_y (
    .clk, .rst, .en, .in_valid(v4), .dividend(DivSteps'(my4)),
    .divisor(DivSteps'(dabs4)), .in_tag(tag_in), .out_valid(vy),
    .quotient(qy), .out_tag(ty));
  fpp_divider #(.Steps(DivSteps), .TagW(TagW)) u_div_s (
    .clk, .rst, .en, .in_valid(v4), .dividend(DivSteps'(ScaleNum)),
    .divisor(DivSteps'(dabs4)), .in_tag(tag_in), .out_valid(vs),
    .quotient(qs), .out_tag(ts));

  // output stage
  logic        vis_o, sgx, sgy;
  logic [15:0] sx, sy;
  assign vis_o = tx[2];
  assign sgx   = tx[1];
  assign sgy   = tx[0];
  assign sx = 16'(cx) + (sgx ? 16'(-qx[15:0]) : qx[15:0]);
  assign sy = 16'(cy) - (sgy ? 16'(-qy[15:0]) : qy[15:0]);

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (en) out_ch.valid <= vx;
    if (en) begin
      out_ch.data.world_x      <= tx[TagW-1 -: 32];
      out_ch.data.world_y      <= tx[TagW-33 -: 32];
      out_ch.data.depth        <= tx[TagW-65 -: 32];
      out_ch.data.visible      <= vis_o;
      out_ch.data.screen_x     <= vis_o ? sx : '0;
      out_ch.data.screen_y     <= vis_o ? sy : '0;
      out_ch.data.sprite_scale <= vis_o ? qs[ScaleW-1:0] : '0;
    end
  end

  // lanes stay in lockstep with matching tags, hidden points carry zero scale, stalled results hold
  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    (vx == vy) && (vx == vs)) else $error("divider lanes out of step");
  a_tags: assert property (@(posedge clk) disable iff (rst)
    vx |-> (ty == tx) && (ts == tx)) else $error("divider tags out of step");
  a_hidden: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.data.visible |-> out_ch.data.sprite_scale == '0)
    else $error("hidden point with scale");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("stalled result changed");
endmodule

// ===== tb/fixed_point_point_projection_test.sv =====
// self-checking testbench for the fixed-point point projection block
`timescale 1ns / 100ps

module fixed_point_point_projection_test;
  import fpp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = RegRow0Lin;
  logic [CfgW-1:0] cfg_data = '0;

  fpp_if #(.payload_t(point_t)) in_ch ();
  fpp_if #(.payload_t(proj_t)) out_ch ();

  fixed_point_point_projection dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // camera matrix and screen center as the block should hold them
  logic [CfgW-1:0] cam_mat [6];
  logic [CenterW-1:0] ctr_x, ctr_y;

  proj_t pending_proj [$];
  bit failed = 1'b0;
  bit no_idle = 1'b0;
  int rx_hold = 0;

  // one matrix term: wrapping product, arithmetic shift back to 8 fraction bits
  function automatic logic [31:0] mat_term(logic [31:0] a, logic [31:0] m);
    logic [31:0] p;
    p = a * m;
    return $signed(p) >>> FracShift;
  endfunction

  function automatic logic [31:0] row_sum(int r, logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z);
    logic [CfgW-1:0] lin, rest;
    lin = cam_mat[2*r];
    rest = cam_mat[2*r+1];
    return rest[63:32] + mat_term(y, lin[63:32]) + mat_term(z, rest[31:0])
         + mat_term(x, lin[31:0]);
  endfunction

  // expected projection of one point under the current setup
  function automatic proj_t project_point(point_t p);
    proj_t e;
    logic [31:0] x, y, z;
    logic [31:0] shx, shy;
    longint d, qx, qy;
    x = p.pos_x >>> FracShift;
    z = p.pos_z >>> FracShift;
    y = p.pos_height >>> FracShift;
    e = '0;
    e.world_x = row_sum(0, x, y, z);
    e.world_y = row_sum(1, x, y, z);
    e.depth = row_sum(2, x, y, z);
    d = longint'(e.depth);
    if (d >= DepthMin) begin
      shx = e.world_x << FracShift;
      shy = e.world_y << FracShift;
      qx = longint'($signed(shx)) / d;
      qy = longint'($signed(shy)) / d;
      e.visible = 1'b1;
      e.screen_x = 16'(longint'(ctr_x) + qx);
      e.screen_y = 16'(longint'(ctr_y) - qy);
      e.sprite_scale = 15'(longint'(ScaleNum) / d);
    end
    return e;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx < RegCenterX) cam_mat[idx] = val;
    else if (idx == RegCenterX) ctr_x = val[CenterW-1:0];
    else ctr_y = val[CenterW-1:0];
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // let every expected result arrive and the pipeline drain
  task automatic drain();
    while (pending_proj.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // offer one request and record its projection once it is taken
  task automatic send_point(point_t p);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= p;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
      @(posedge clk);
    end
    pending_proj.push_back(project_point(p));
    @(posedge clk);
  endtask

  // receiver: random stalls, a counted hold-off when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= 35);
      end
    end
  end

  // result checker, sampled on the falling edge ahead of the accepting edge
  always @(negedge clk) begin
    proj_t e, a;
    if (!rst && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (pending_proj.size() == 0) begin
        $error("unexpected result world_x=%h", a.world_x);
        failed = 1'b1;
      end else begin
        e = pending_proj.pop_front();
        if (a.world_x !== e.world_x) begin
          $error("world_x exp %h got %h", e.world_x, a.world_x); failed = 1'b1;
        end
        if (a.world_y !== e.world_y) begin
          $error("world_y exp %h got %h", e.world_y, a.world_y); failed = 1'b1;
        end
        if (a.depth !== e.depth) begin
          $error("depth exp %h got %h", e.depth, a.depth); failed = 1'b1;
        end
        if (a.visible !== e.visible) begin
          $error("visible exp %b got %b", e.visible, a.visible); failed = 1'b1;
        end
        if (a.screen_x !== e.screen_x) begin
          $error("screen_x exp %h got %h", e.screen_x, a.screen_x); failed = 1'b1;
        end
        if (a.screen_y !== e.screen_y) begin
          $error("screen_y exp %h got %h", e.screen_y, a.screen_y); failed = 1'b1;
        end
        if (a.sprite_scale !== e.sprite_scale) begin
          $error("sprite_scale exp %h got %h", e.sprite_scale, a.sprite_scale);
          failed = 1'b1;
        end
      end
    end
  end

  // directed setups: 0 reset values, 1 fixed depth 0x400, 2 unit axes with depth
  // just short of visible, 3 unit axes at min depth with extreme centers,
  // 4 depth falling with x so it goes negative
  task automatic load_setup(int sel);
    write_reg(RegRow0Lin, sel >= 2 ? 64'h0000_0000_0000_0100 : 64'h0);
    write_reg(RegRow1Lin, sel >= 2 ? 64'h0000_0100_0000_0000 : 64'h0);
    write_reg(RegRow2Lin, sel == 4 ? 64'h0000_0000_FFFF_FF00 : 64'h0);
    write_reg(RegRow2Rest, sel == 2 ? 64'h0000_03FF_0000_0000 :
                           sel == 0 ? 64'h0 : 64'h0000_0400_0000_0000);
    write_reg(RegCenterX, sel == 3 ? 64'd0 : 64'd212);
    write_reg(RegCenterY, sel == 3 ? 64'd4095 : 64'd120);
    end_writes();
  endtask

  typedef struct {
    int setup;
    point_t pt;
    bit typed;
    proj_t res;
  } stim_row_t;

  localparam int NumRows = 20;
  localparam logic [31:0] SMax = 32'h7FFF_FFFF;
  localparam logic [31:0] SMin = 32'h8000_0000;

  stim_row_t stim_rows [NumRows] = '{
    '{0, '{32'h0, 32'h0, 32'h0}, 1'b1, '0},
    '{0, '{SMax, SMax, SMax}, 1'b1, '0},
    '{0, '{SMin, SMin, SMin}, 1'b1, '0},
    '{0, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '0},
    '{0, '{SMin, SMax, 32'h0}, 1'b1, '0},
    '{1, '{32'h0, 32'h0, 32'h0}, 1'b1,
         '{32'h0, 32'h0, 32'h400, 1'b1, 16'd212, 16'd120, 15'h4000}},
    '{1, '{SMax, SMin, SMax}, 1'b0, '0},
    '{1, '{SMin, SMax, SMin}, 1'b0, '0},
    '{2, '{32'h1_0000, 32'h0, 32'h2_0000}, 1'b1,
         '{32'h100, 32'h200, 32'h3FF, 1'b0, 16'h0, 16'h0, 15'h0}},
    '{2, '{SMax, 32'h0, SMin}, 1'b0, '0},
    '{3, '{32'h1_0000, 32'h0, 32'h2_0000}, 1'b0, '0},
    '{3, '{SMax, SMax, SMax}, 1'b0, '0},
    '{3, '{SMin, SMin, SMin}, 1'b0, '0},
    '{3, '{32'hFFFF_0000, 32'h0, 32'hFFFE_0000}, 1'b0, '0},
    '{3, '{32'h0080_0000, 32'h5, 32'hFF80_0000}, 1'b0, '0},
    '{4, '{32'h0, 32'h0, 32'h0}, 1'b0, '0},
    '{4, '{32'h0004_0000, 32'h0, 32'h0}, 1'b0, '0},
    '{4, '{32'h0005_0000, 32'h0, 32'h1_0000}, 1'b0, '0},
    '{4, '{SMax, 32'h0, 32'h0}, 1'b0, '0},
    '{4, '{SMin, 32'h0, SMax}, 1'b0, '0}
  };

  function automatic logic [31:0] rand_entry(int mode);
    if (mode == 0) return $urandom;
    return $urandom_range(1023) - 512;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? SMax : SMin;
      default: return $urandom_range(13_107_200) - 6_553_600;
    endcase
  endfunction

  // random setup; phase 0 and 1 pin the centers, phase 2 an all-ones matrix
  task automatic random_setup(int ph);
    int mode;
    logic [CfgW-1:0] d;
    mode = $urandom_range(3) == 0 ? 0 : 1;
    for (int r = 0; r < 6; r++) begin
      d = {rand_entry(mode), rand_entry(mode)};
      if (r == RegRow2Rest && $urandom_range(3) != 0)
        d[63:32] = $urandom_range(32'h0010_0000, 32'h300);
      if (ph == 2) d = '1;
      write_reg(CfgIdxW'(r), d);
    end
    write_reg(RegCenterX, ph == 0 ? 64'd0 : ph == 1 ? 64'd4095 : 64'($urandom_range(4095)));
    write_reg(RegCenterY, ph == 0 ? 64'd0 : ph == 1 ? 64'd4095 : 64'($urandom_range(4095)));
    end_writes();
  endtask

  initial begin
    int cur;
    point_t p;
    proj_t e;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    foreach (cam_mat[i]) cam_mat[i] = '0;
    ctr_x = 12'd212;
    ctr_y = 12'd120;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    cur = 0;
    for (int i = 0; i < NumRows; i++) begin
      if (stim_rows[i].setup != cur) begin
        in_ch.valid <= 1'b0;
        drain();
        cur = stim_rows[i].setup;
        load_setup(cur);
      end
      if (stim_rows[i].typed) begin
        e = project_point(stim_rows[i].pt);
        if (e !== stim_rows[i].res) begin
          $error("table row %0d: predicted %h, typed %h", i, e, stim_rows[i].res);
          failed = 1'b1;
        end
      end
      send_point(stim_rows[i].pt);
    end

    // random phases
    for (int ph = 0; ph < 11; ph++) begin
      in_ch.valid <= 1'b0;
      drain();
      random_setup(ph);
      no_idle = (ph == 3);
      if (ph == 5) rx_hold = 300;
      for (int n = 0; n < 150; n++) begin
        p.pos_x = rand_coord();
        p.pos_z = rand_coord();
        p.pos_height = rand_coord();
        send_point(p);
      end
    end
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;
    drain();

    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end
endmodule
